>>> hw/rtl/ata_pio_host_sequencer_assert.svh
// assertion macros shared by the sequencer modules
`ifndef ATA_PIO_HOST_SEQUENCER_ASSERT_SVH
`define ATA_PIO_HOST_SEQUENCER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define AHS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AHS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define AHS_ASSERT_IMP(label, clk, rst, ante, cons, msg)

`define AHS_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> hw/rtl/ahs_pkg.sv
`default_nettype none

package ahs_pkg;

   localparam int PHASE_W = 5;

   localparam logic [8:0] WORDS_PER_SECTOR = 9'd256;
   localparam logic [8:0] MAX_SECTORS      = 9'd256;

   // input operation codes
   localparam logic [2:0] OP_IDENTIFY = 3'd0;
   localparam logic [2:0] OP_READ     = 3'd1;
   localparam logic [2:0] OP_WRITE    = 3'd2;
   localparam logic [2:0] OP_RESPONSE = 3'd3;
   localparam logic [2:0] OP_SUPPLY   = 3'd4;

   // command kinds as stored
   localparam logic [1:0] CMD_IDENTIFY = 2'd0;
   localparam logic [1:0] CMD_READ     = 2'd1;
   localparam logic [1:0] CMD_WRITE    = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_ACCESS = 2'd0;
   localparam logic [1:0] KIND_WORD   = 2'd1;
   localparam logic [1:0] KIND_WANT   = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   // completion codes
   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_NO_DRIVE  = 3'd1;
   localparam logic [2:0] STS_NOT_ATA   = 3'd2;
   localparam logic [2:0] STS_ID_ERROR  = 3'd3;
   localparam logic [2:0] STS_DEV_ERROR = 3'd4;

   // primary bus ports
   localparam logic [9:0] PORT_DATA    = 10'h1F0;
   localparam logic [9:0] PORT_COUNT   = 10'h1F2;
   localparam logic [9:0] PORT_LBA_LO  = 10'h1F3;
   localparam logic [9:0] PORT_LBA_MID = 10'h1F4;
   localparam logic [9:0] PORT_LBA_HI  = 10'h1F5;
   localparam logic [9:0] PORT_DRIVE   = 10'h1F6;
   localparam logic [9:0] PORT_STATUS  = 10'h1F7;
   localparam logic [9:0] PORT_ALT     = 10'h3F6;

   // device commands and register values
   localparam logic [7:0] ATA_IDENTIFY  = 8'hEC;
   localparam logic [7:0] ATA_READ      = 8'h20;
   localparam logic [7:0] ATA_WRITE     = 8'h30;
   localparam logic [7:0] ATA_FLUSH     = 8'hE7;
   localparam logic [7:0] SEL_IDENTIFY  = 8'hA0;
   localparam logic [3:0] SEL_LBA_HIGH  = 4'hE;

   // status bits
   localparam int BIT_BSY = 7;
   localparam int BIT_DRQ = 3;
   localparam int BIT_ERR = 0;

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  bus_port;
      logic        bus_write;
      logic        bus_word;
      logic [15:0] data;
      logic [2:0]  status_code;
      logic        last;
   } rsp_type;

   // results handed from the sequencer to the result queue
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      rsp_type            rsp;
   } step_type;

   function automatic rsp_type mk_rd8(input logic [9:0] port);
      rsp_type r;
      r = '0;
      r.kind = KIND_ACCESS;
      r.bus_port = port;
      return r;
   endfunction

   function automatic rsp_type mk_wr8(input logic [9:0] port, input logic [7:0] value);
      rsp_type r;
      r = '0;
      r.kind = KIND_ACCESS;
      r.bus_port = port;
      r.bus_write = 1'b1;
      r.data = {8'h00, value};
      return r;
   endfunction

   function automatic rsp_type mk_data_rd();
      rsp_type r;
      r = '0;
      r.kind = KIND_ACCESS;
      r.bus_port = PORT_DATA;
      r.bus_word = 1'b1;
      return r;
   endfunction

   function automatic rsp_type mk_data_wr(input logic [15:0] value);
      rsp_type r;
      r = '0;
      r.kind = KIND_ACCESS;
      r.bus_port = PORT_DATA;
      r.bus_write = 1'b1;
      r.bus_word = 1'b1;
      r.data = value;
      return r;
   endfunction

   function automatic rsp_type mk_word(input logic [15:0] value);
      rsp_type r;
      r = '0;
      r.kind = KIND_WORD;
      r.data = value;
      return r;
   endfunction

   function automatic rsp_type mk_want();
      rsp_type r;
      r = '0;
      r.kind = KIND_WANT;
      return r;
   endfunction

   function automatic rsp_type mk_done(input logic [2:0] code);
      rsp_type r;
      r = '0;
      r.kind = KIND_DONE;
      r.status_code = code;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ata_pio_host_sequencer.sv
// ATA PIO host sequencer, primary bus, master drive, 28-bit LBA. Send identify, read or
// write commands on req_; the block answers with one port access at a time on rsp_ and
// each access must be answered by a bus response transfer (operation 3) carrying the
// value read (low byte for status reads). Read and identify data words come back as
// word-delivered results; for a write each word is requested and must be supplied with
// operation 4. Every input item is taken into an input register and worked off by the
// sequencer, whose one or two results go into a four-entry result queue. An item is
// accepted in every cycle as long as the queue has room for two results, so the
// sustained rate is one item per cycle when the result side takes a transfer every
// cycle; a data-in response yields two results and so takes two result transfers.
// Commands while busy, responses while idle or waiting for a word, unrequested words and
// unused operation codes are consumed and give no result. No clearing pass after reset.
`default_nettype none

module ata_pio_host_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,

   // command and response channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // start_lba[27:0], sector_count[36:28], bus_read_data[52:37], write_word[68:53], zero pad
   input  wire logic [71:0] req_tdata,
   // operation[2:0]
   input  wire logic [2:0]  req_tuser,

   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // bus_port[9:0], bus_write[10], bus_word[11], data[27:12], status_code[30:28], zero pad
   output logic [31:0]      rsp_tdata,
   // kind[1:0]
   output logic [1:0]       rsp_tuser,
   // last result of the input item
   output logic             rsp_tlast
);

   ahs_pkg::push_type push;
   ahs_pkg::rsp_type  head;
   logic              space;

   // sequencer: input register, state and step logic
   ahs_core u_core (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .operation     (req_tuser),
      .start_lba     (req_tdata[27:0]),
      .sector_count  (req_tdata[36:28]),
      .bus_read_data (req_tdata[52:37]),
      .write_word    (req_tdata[68:53]),
      .space         (space),
      .push          (push)
   );

   // result queue decouples the result side from the sequencer
   ahs_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (space),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (head)
   );

   // pack the head entry onto the stream
   assign rsp_tdata = {1'b0, head.status_code, head.data, head.bus_word, head.bus_write,
                       head.bus_port};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

`default_nettype wire

>>> hw/rtl/ahs_rsp_queue.sv
`default_nettype none

`include "ata_pio_host_sequencer_assert.svh"

module ahs_rsp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ahs_pkg::push_type push,
   output logic                  space,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ahs_pkg::rsp_type      rsp_data
);

   ahs_pkg::rsp_type q_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   // room for the worst case of two results
   assign space     = (count_ff <= 3'd2);
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = q_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push.count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         q_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         q_ff[wr_ptr_ff + 2'd1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `AHS_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= 3'd4, "queue overfilled")
   `AHS_ASSERT_IMP(a_push_room, clock, reset, push.count != 2'd0, count_ff <= 3'd2, "push without room")
   `AHS_ASSERT_IMP(a_empty_ptrs, clock, reset, count_ff == 3'd0, wr_ptr_ff == rd_ptr_ff, "pointer skew")

endmodule

`default_nettype wire

>>> hw/rtl/ahs_core.sv
`default_nettype none

`include "ata_pio_host_sequencer_assert.svh"

module ahs_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [2:0]        operation,
   input  wire logic [27:0]       start_lba,
   input  wire logic [8:0]        sector_count,
   input  wire logic [15:0]       bus_read_data,
   input  wire logic [15:0]       write_word,
   input  wire logic              space,
   output ahs_pkg::push_type      push
);

   localparam int PW = ahs_pkg::PHASE_W;

   localparam logic [PW-1:0] PH_IDLE       = 5'd0;
   localparam logic [PW-1:0] PH_PRE_BSY    = 5'd1;
   localparam logic [PW-1:0] PH_SEL        = 5'd2;
   localparam logic [PW-1:0] PH_PRE_DELAY  = 5'd3;
   localparam logic [PW-1:0] PH_TF_COUNT   = 5'd4;
   localparam logic [PW-1:0] PH_TF_LOW     = 5'd5;
   localparam logic [PW-1:0] PH_TF_MID     = 5'd6;
   localparam logic [PW-1:0] PH_TF_HIGH    = 5'd7;
   localparam logic [PW-1:0] PH_CMD        = 5'd8;
   localparam logic [PW-1:0] PH_ID_PRESENT = 5'd9;
   localparam logic [PW-1:0] PH_ID_BSY     = 5'd10;
   localparam logic [PW-1:0] PH_ID_MID     = 5'd11;
   localparam logic [PW-1:0] PH_ID_HIGH    = 5'd12;
   localparam logic [PW-1:0] PH_ID_DRQ     = 5'd13;
   localparam logic [PW-1:0] PH_ID_ERR     = 5'd14;
   localparam logic [PW-1:0] PH_DATA_IN    = 5'd15;
   localparam logic [PW-1:0] PH_XFER_POLL  = 5'd16;
   localparam logic [PW-1:0] PH_WANT_WORD  = 5'd17;
   localparam logic [PW-1:0] PH_DATA_OUT   = 5'd18;
   localparam logic [PW-1:0] PH_TINY       = 5'd19;
   localparam logic [PW-1:0] PH_SECT_DELAY = 5'd20;
   localparam logic [PW-1:0] PH_FLUSH_CMD  = 5'd21;
   localparam logic [PW-1:0] PH_FLUSH_POLL = 5'd22;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [2:0]  op_ff;
   logic [27:0] lba_ff;
   logic [8:0]  cnt_ff;
   logic [15:0] rdata_ff;
   logic [15:0] wword_ff;

   // sequencer state
   logic [PW-1:0] phase_ff, phase_in;
   logic [1:0]    kind_ff, kind_in;
   logic [27:0]   addr_ff, addr_in;
   logic [8:0]    total_ff, total_in;
   logic [8:0]    sidx_ff, sidx_in;
   logic [8:0]    widx_ff, widx_in;
   logic [2:0]    delay_ff, delay_in;

   logic             fire;
   logic             take;
   logic [7:0]       st;
   logic             ident;
   logic [8:0]       widx_inc;
   logic [8:0]       sidx_inc;
   logic [2:0]       delay_inc;
   logic [1:0]       nres;
   ahs_pkg::rsp_type res_a;
   ahs_pkg::rsp_type res_b;
   ahs_pkg::step_type ns;
   logic             done_push;

   // after a sector: poll for the next one, flush a write, or finish
   function automatic ahs_pkg::step_type next_sector(input logic [8:0] idx,
                                                     input logic [8:0] total,
                                                     input logic [1:0] kind);
      ahs_pkg::step_type r;
      if (idx < total) begin
         r.phase = PH_XFER_POLL;
         r.rsp   = ahs_pkg::mk_rd8(ahs_pkg::PORT_STATUS);
      end else if (kind == ahs_pkg::CMD_WRITE) begin
         r.phase = PH_FLUSH_CMD;
         r.rsp   = ahs_pkg::mk_wr8(ahs_pkg::PORT_STATUS, ahs_pkg::ATA_FLUSH);
      end else begin
         r.phase = PH_IDLE;
         r.rsp   = ahs_pkg::mk_done(ahs_pkg::STS_OK);
      end
      return r;
   endfunction

   assign fire        = in_valid_ff && space;
   assign req_ready   = !in_valid_ff || fire;
   assign take        = req_valid && req_ready;
   assign in_valid_in = take || (in_valid_ff && !fire);

   assign st        = rdata_ff[7:0];
   assign ident     = (kind_ff == ahs_pkg::CMD_IDENTIFY);
   assign widx_inc  = widx_ff + 9'd1;
   assign sidx_inc  = sidx_ff + 9'd1;
   assign delay_inc = delay_ff + 3'd1;

   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      addr_in  = addr_ff;
      total_in = total_ff;
      sidx_in  = sidx_ff;
      widx_in  = widx_ff;
      delay_in = delay_ff;
      res_a    = '0;
      res_b    = '0;
      nres     = 2'd0;
      ns       = '0;

      if (fire) begin
         unique case (op_ff) inside
            ahs_pkg::OP_IDENTIFY, ahs_pkg::OP_READ, ahs_pkg::OP_WRITE: begin
               if (phase_ff == PH_IDLE) begin
                  kind_in  = op_ff[1:0];
                  sidx_in  = 9'd0;
                  widx_in  = 9'd0;
                  delay_in = 3'd0;
                  nres     = 2'd1;
                  if (op_ff == ahs_pkg::OP_IDENTIFY) begin
                     addr_in  = 28'd0;
                     total_in = 9'd0;
                     phase_in = PH_SEL;
                     res_a    = ahs_pkg::mk_wr8(ahs_pkg::PORT_DRIVE, ahs_pkg::SEL_IDENTIFY);
                  end else begin
                     addr_in  = lba_ff;
                     total_in = (cnt_ff > ahs_pkg::MAX_SECTORS) ? ahs_pkg::MAX_SECTORS
                                                                : cnt_ff;
                     phase_in = PH_PRE_BSY;
                     res_a    = ahs_pkg::mk_rd8(ahs_pkg::PORT_STATUS);
                  end
               end
            end
            ahs_pkg::OP_RESPONSE: begin
               if (phase_ff != PH_IDLE && phase_ff != PH_WANT_WORD) begin
                  nres = 2'd1;
                  unique case (phase_ff)
                     PH_PRE_BSY: begin
                        if (st[ahs_pkg::BIT_BSY]) begin
                           res_a = ahs_pkg::mk_rd8(ahs_pkg::PORT_STATUS);
                        end else begin
                           phase_in = PH_SEL;
                           res_a    = ahs_pkg::mk_wr8(ahs_pkg::PORT_DRIVE,
                                                      {ahs_pkg::SEL_LBA_HIGH, addr_ff[27:24]});
                        end
                     end
                     PH_SEL: begin
                        phase_in = PH_PRE_DELAY;
                        delay_in = 3'd0;
                        res_a    = ahs_pkg::mk_rd8(ahs_pkg::PORT_ALT);
                     end
                     PH_PRE_DELAY: begin
                        delay_in = delay_inc;
                        if (delay_inc < 3'd4) begin
                           res_a = ahs_pkg::mk_rd8(ahs_pkg::PORT_ALT);
                        end else begin
                           phase_in = PH_TF_COUNT;
                           res_a    = ahs_pkg::mk_wr8(ahs_pkg::PORT_COUNT, total_ff[7:0]);
                        end
                     end
                     PH_TF_COUNT: begin
                        phase_in = PH_TF_LOW;
                        res_a    = ahs_pkg::mk_wr8(ahs_pkg::PORT_LBA_LO, addr_ff[7:0]);
                     end
                     PH_TF_LOW: begin
                        phase_in = PH_TF_MID;
                        res_a    = ahs_pkg::mk_wr8(ahs_pkg::PORT_LBA_MID, addr_ff[15:8]);
                     end
                     PH_TF_MID: begin
                        phase_in = PH_TF_HIGH;
                        res_a    = ahs_pkg::mk_wr8(ahs_pkg::PORT_LBA_HI, addr_ff[23:16]);
                     end
                     PH_TF_HIGH: begin
                        phase_in = PH_CMD;
                        res_a    = ahs_pkg::mk_wr8(ahs_pkg::PORT_STATUS,
                                      ident ? ahs_pkg::ATA_IDENTIFY :
                                      (kind_ff == ahs_pkg::CMD_READ) ? ahs_pkg::ATA_READ
                                                                     : ahs_pkg::ATA_WRITE);
                     end
                     PH_CMD: begin
                        if (ident) begin
                           phase_in = PH_ID_PRESENT;
                           res_a    = ahs_pkg::mk_rd8(ahs_pkg::PORT_STATUS);
                        end else begin
                           ns       = next_sector(sidx_ff, total_ff, kind_ff);
                           phase_in = ns.phase;
                           res_a    = ns.rsp;
                        end
                     end
                     PH_ID_PRESENT: begin
                        if (st == 8'h00) begin
                           phase_in = PH_IDLE;
                           res_a    = ahs_pkg::mk_done(ahs_pkg::STS_NO_DRIVE);
                        end else begin
                           phase_in = PH_ID_BSY;
                           res_a    = ahs_pkg::mk_rd8(ahs_pkg::PORT_STATUS);
                        end
                     end
                     PH_ID_BSY: begin
                        if (st[ahs_pkg::BIT_BSY]) begin
                           res_a = ahs_pkg::mk_rd8(ahs_pkg::PORT_STATUS);
                        end else begin
                           phase_in = PH_ID_MID;
                           res_a    = ahs_pkg::mk_rd8(ahs_pkg::PORT_LBA_MID);
                        end
                     end
                     PH_ID_MID: begin
                        if (st != 8'h00) begin
                           phase_in = PH_IDLE;
                           res_a    = ahs_pkg::mk_done(ahs_pkg::STS_NOT_ATA);
                        end else begin
                           phase_in = PH_ID_HIGH;
                           res_a    = ahs_pkg::mk_rd8(ahs_pkg::PORT_LBA_HI);
                        end
                     end
                     PH_ID_HIGH: begin
                        if (st != 8'h00) begin
                           phase_in = PH_IDLE;
                           res_a    = ahs_pkg::mk_done(ahs_pkg::STS_NOT_ATA);
                        end else begin
                           phase_in = PH_ID_DRQ;
                           res_a    = ahs_pkg::mk_rd8(ahs_pkg::PORT_STATUS);
                        end
                     end
                     PH_ID_DRQ: begin
                        if (st[ahs_pkg::BIT_DRQ]) begin
                           phase_in = PH_DATA_IN;
                           widx_in  = 9'd0;
                           res_a    = ahs_pkg::mk_data_rd();
                        end else begin
                           phase_in = PH_ID_ERR;
                           res_a    = ahs_pkg::mk_rd8(ahs_pkg::PORT_STATUS);
                        end
                     end
                     PH_ID_ERR: begin
                        if (st[ahs_pkg::BIT_ERR]) begin
                           phase_in = PH_IDLE;
                           res_a    = ahs_pkg::mk_done(ahs_pkg::STS_ID_ERROR);
                        end else begin
                           phase_in = PH_ID_DRQ;
                           res_a    = ahs_pkg::mk_rd8(ahs_pkg::PORT_STATUS);
                        end
                     end
                     PH_XFER_POLL: begin
                        if (st[ahs_pkg::BIT_ERR]) begin
                           phase_in = PH_IDLE;
                           res_a    = ahs_pkg::mk_done(ahs_pkg::STS_DEV_ERROR);
                        end else if (!st[ahs_pkg::BIT_BSY] && st[ahs_pkg::BIT_DRQ]) begin
                           widx_in = 9'd0;
                           if (kind_ff == ahs_pkg::CMD_WRITE) begin
                              phase_in = PH_WANT_WORD;
                              res_a    = ahs_pkg::mk_want();
                           end else begin
                              phase_in = PH_DATA_IN;
                              res_a    = ahs_pkg::mk_data_rd();
                           end
                        end else begin
                           res_a = ahs_pkg::mk_rd8(ahs_pkg::PORT_STATUS);
                        end
                     end
                     PH_DATA_IN: begin
                        nres    = 2'd2;
                        res_a   = ahs_pkg::mk_word(rdata_ff);
                        widx_in = widx_inc;
                        if (widx_inc < ahs_pkg::WORDS_PER_SECTOR) begin
                           res_b = ahs_pkg::mk_data_rd();
                        end else if (ident) begin
                           phase_in = PH_IDLE;
                           res_b    = ahs_pkg::mk_done(ahs_pkg::STS_OK);
                        end else begin
                           phase_in = PH_SECT_DELAY;
                           delay_in = 3'd0;
                           res_b    = ahs_pkg::mk_rd8(ahs_pkg::PORT_ALT);
                        end
                     end
                     PH_DATA_OUT: begin
                        phase_in = PH_TINY;
                        res_a    = ahs_pkg::mk_rd8(ahs_pkg::PORT_ALT);
                     end
                     PH_TINY: begin
                        widx_in = widx_inc;
                        if (widx_inc < ahs_pkg::WORDS_PER_SECTOR) begin
                           phase_in = PH_WANT_WORD;
                           res_a    = ahs_pkg::mk_want();
                        end else begin
                           phase_in = PH_SECT_DELAY;
                           delay_in = 3'd0;
                           res_a    = ahs_pkg::mk_rd8(ahs_pkg::PORT_ALT);
                        end
                     end
                     PH_SECT_DELAY: begin
                        delay_in = delay_inc;
                        if (delay_inc < 3'd4) begin
                           res_a = ahs_pkg::mk_rd8(ahs_pkg::PORT_ALT);
                        end else begin
                           sidx_in  = sidx_inc;
                           ns       = next_sector(sidx_inc, total_ff, kind_ff);
                           phase_in = ns.phase;
                           res_a    = ns.rsp;
                        end
                     end
                     PH_FLUSH_CMD: begin
                        phase_in = PH_FLUSH_POLL;
                        res_a    = ahs_pkg::mk_rd8(ahs_pkg::PORT_STATUS);
                     end
                     PH_FLUSH_POLL: begin
                        if (st[ahs_pkg::BIT_BSY]) begin
                           res_a = ahs_pkg::mk_rd8(ahs_pkg::PORT_STATUS);
                        end else begin
                           phase_in = PH_IDLE;
                           res_a    = ahs_pkg::mk_done(ahs_pkg::STS_OK);
                        end
                     end
                     default: begin
                        nres = 2'd0;
                     end
                  endcase
               end
            end
            ahs_pkg::OP_SUPPLY: begin
               if (phase_ff == PH_WANT_WORD) begin
                  phase_in = PH_DATA_OUT;
                  nres     = 2'd1;
                  res_a    = ahs_pkg::mk_data_wr(wword_ff);
               end
            end
            default: begin
               nres = 2'd0;
            end
         endcase
      end

      // mark the final result of this item
      if (nres == 2'd1) begin
         res_a.last = 1'b1;
      end
      if (nres == 2'd2) begin
         res_b.last = 1'b1;
      end
   end

   assign push.count  = nres;
   assign push.first  = res_a;
   assign push.second = res_b;

   assign done_push = ((nres == 2'd1) && (res_a.kind == ahs_pkg::KIND_DONE)) ||
                      ((nres == 2'd2) && (res_b.kind == ahs_pkg::KIND_DONE));

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff    <= operation;
         lba_ff   <= start_lba;
         cnt_ff   <= sector_count;
         rdata_ff <= bus_read_data;
         wword_ff <= write_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_IDLE;
         kind_ff     <= 2'd0;
         addr_ff     <= 28'd0;
         total_ff    <= 9'd0;
         sidx_ff     <= 9'd0;
         widx_ff     <= 9'd0;
         delay_ff    <= 3'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         kind_ff     <= kind_in;
         addr_ff     <= addr_in;
         total_ff    <= total_in;
         sidx_ff     <= sidx_in;
         widx_ff     <= widx_in;
         delay_ff    <= delay_in;
      end
   end

   `AHS_ASSERT_IMP(a_pair_only_data_in, clock, reset, nres == 2'd2, phase_ff == PH_DATA_IN, "two results outside data in")
   `AHS_ASSERT_NXT(a_done_to_idle, clock, reset, done_push, phase_ff == PH_IDLE, "done without idle")
   `AHS_ASSERT_IMP(a_push_needs_fire, clock, reset, nres != 2'd0, fire, "results without item")
   `AHS_ASSERT_IMP(a_delay_bound, clock, reset, 1'b1, delay_ff <= 3'd4, "delay count out of range")

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none

module tb_top;
   import ahs_pkg::*;

   // sequencer position as the predictor tracks it
   typedef enum logic [4:0] {
      S_IDLE, S_WAIT_READY, S_SELECT, S_SETTLE, S_TF_COUNT, S_TF_LBA0, S_TF_LBA1,
      S_TF_LBA2, S_COMMAND, S_ID_PROBE, S_ID_BUSY, S_ID_SIG_MID, S_ID_SIG_HIGH,
      S_ID_DRQ, S_ID_ERR, S_READ_WORD, S_SECTOR_POLL, S_NEED_WORD, S_WRITE_WORD,
      S_WRITE_SETTLE, S_SECTOR_DELAY, S_FLUSH, S_FLUSH_POLL
   } seq_pos_e;

   // what the emulated drive is going to do for the running command
   typedef enum logic [2:0] {
      PLAN_CLEAN, PLAN_NO_DRIVE, PLAN_NOT_ATA, PLAN_ID_ERROR, PLAN_DEV_ERROR
   } drive_fault_e;

   // predicts the results of every accepted transfer and checks them in order
   class pio_tracker;
      rsp_type    expected[$];
      rsp_type    made[$];
      int         errors;
      seq_pos_e   cur;
      logic [1:0] cmd;
      logic [27:0] lba;
      logic [8:0] total;
      logic [8:0] sect;
      logic [8:0] word;
      logic [2:0] dly;

      function new();
         errors = 0;
         cur    = S_IDLE;
         cmd    = CMD_IDENTIFY;
         lba    = '0;
         total  = '0;
         sect   = '0;
         word   = '0;
         dly    = '0;
      endfunction

      // at most two results per input item
      function void put(logic [1:0] k, logic [9:0] port, logic wr, logic wd,
                        logic [15:0] d, logic [2:0] code);
         rsp_type r;
         if (made.size() >= 2) return;
         r.kind        = k;
         r.bus_port    = port;
         r.bus_write   = wr;
         r.bus_word    = wd;
         r.data        = d;
         r.status_code = code;
         r.last        = 1'b0;
         made.push_back(r);
      endfunction

      function void rd8(logic [9:0] port);
         put(KIND_ACCESS, port, 1'b0, 1'b0, 16'h0000, '0);
      endfunction

      function void wr8(logic [9:0] port, logic [7:0] v);
         put(KIND_ACCESS, port, 1'b1, 1'b0, {8'h00, v}, '0);
      endfunction

      function void done(logic [2:0] code);
         cur = S_IDLE;
         put(KIND_DONE, '0, 1'b0, 1'b0, 16'h0000, code);
      endfunction

      function void next_sector();
         if (sect < total) begin
            cur = S_SECTOR_POLL;
            rd8(PORT_STATUS);
         end else if (cmd == CMD_WRITE) begin
            cur = S_FLUSH;
            wr8(PORT_STATUS, ATA_FLUSH);
         end else begin
            done(STS_OK);
         end
      endfunction

      function void respond(logic [15:0] rd);
         logic [7:0] st;
         logic       ident;
         st    = rd[7:0];
         ident = (cmd == CMD_IDENTIFY);
         case (cur)
            S_WAIT_READY: begin
               if (st[BIT_BSY]) rd8(PORT_STATUS);
               else begin
                  cur = S_SELECT;
                  wr8(PORT_DRIVE, {SEL_LBA_HIGH, lba[27:24]});
               end
            end
            S_SELECT: begin
               cur = S_SETTLE;
               dly = '0;
               rd8(PORT_ALT);
            end
            S_SETTLE: begin
               dly = dly + 3'd1;
               if (dly < 3'd4) rd8(PORT_ALT);
               else begin
                  cur = S_TF_COUNT;
                  wr8(PORT_COUNT, ident ? 8'h00 : total[7:0]);
               end
            end
            S_TF_COUNT: begin
               cur = S_TF_LBA0;
               wr8(PORT_LBA_LO, ident ? 8'h00 : lba[7:0]);
            end
            S_TF_LBA0: begin
               cur = S_TF_LBA1;
               wr8(PORT_LBA_MID, ident ? 8'h00 : lba[15:8]);
            end
            S_TF_LBA1: begin
               cur = S_TF_LBA2;
               wr8(PORT_LBA_HI, ident ? 8'h00 : lba[23:16]);
            end
            S_TF_LBA2: begin
               cur = S_COMMAND;
               wr8(PORT_STATUS, ident ? ATA_IDENTIFY : (cmd == CMD_READ ? ATA_READ : ATA_WRITE));
            end
            S_COMMAND: begin
               if (ident) begin
                  cur = S_ID_PROBE;
                  rd8(PORT_STATUS);
               end else begin
                  next_sector();
               end
            end
            S_ID_PROBE: begin
               if (st == 8'h00) done(STS_NO_DRIVE);
               else begin
                  cur = S_ID_BUSY;
                  rd8(PORT_STATUS);
               end
            end
            S_ID_BUSY: begin
               if (st[BIT_BSY]) rd8(PORT_STATUS);
               else begin
                  cur = S_ID_SIG_MID;
                  rd8(PORT_LBA_MID);
               end
            end
            S_ID_SIG_MID: begin
               if (st != 8'h00) done(STS_NOT_ATA);
               else begin
                  cur = S_ID_SIG_HIGH;
                  rd8(PORT_LBA_HI);
               end
            end
            S_ID_SIG_HIGH: begin
               if (st != 8'h00) done(STS_NOT_ATA);
               else begin
                  cur = S_ID_DRQ;
                  rd8(PORT_STATUS);
               end
            end
            S_ID_DRQ: begin
               if (st[BIT_DRQ]) begin
                  cur  = S_READ_WORD;
                  word = '0;
                  put(KIND_ACCESS, PORT_DATA, 1'b0, 1'b1, 16'h0000, '0);
               end else begin
                  cur = S_ID_ERR;
                  rd8(PORT_STATUS);
               end
            end
            S_ID_ERR: begin
               if (st[BIT_ERR]) done(STS_ID_ERROR);
               else begin
                  cur = S_ID_DRQ;
                  rd8(PORT_STATUS);
               end
            end
            S_SECTOR_POLL: begin
               if (st[BIT_ERR]) done(STS_DEV_ERROR);
               else if (!st[BIT_BSY] && st[BIT_DRQ]) begin
                  word = '0;
                  if (cmd == CMD_WRITE) begin
                     cur = S_NEED_WORD;
                     put(KIND_WANT, '0, 1'b0, 1'b0, 16'h0000, '0);
                  end else begin
                     cur = S_READ_WORD;
                     put(KIND_ACCESS, PORT_DATA, 1'b0, 1'b1, 16'h0000, '0);
                  end
               end else begin
                  rd8(PORT_STATUS);
               end
            end
            S_READ_WORD: begin
               put(KIND_WORD, '0, 1'b0, 1'b0, rd, '0);
               word = word + 9'd1;
               if (word < WORDS_PER_SECTOR)
                  put(KIND_ACCESS, PORT_DATA, 1'b0, 1'b1, 16'h0000, '0);
               else if (ident) done(STS_OK);
               else begin
                  cur = S_SECTOR_DELAY;
                  dly = '0;
                  rd8(PORT_ALT);
               end
            end
            S_WRITE_WORD: begin
               cur = S_WRITE_SETTLE;
               rd8(PORT_ALT);
            end
            S_WRITE_SETTLE: begin
               word = word + 9'd1;
               if (word < WORDS_PER_SECTOR) begin
                  cur = S_NEED_WORD;
                  put(KIND_WANT, '0, 1'b0, 1'b0, 16'h0000, '0);
               end else begin
                  cur = S_SECTOR_DELAY;
                  dly = '0;
                  rd8(PORT_ALT);
               end
            end
            S_SECTOR_DELAY: begin
               dly = dly + 3'd1;
               if (dly < 3'd4) rd8(PORT_ALT);
               else begin
                  sect = sect + 9'd1;
                  next_sector();
               end
            end
            S_FLUSH: begin
               cur = S_FLUSH_POLL;
               rd8(PORT_STATUS);
            end
            S_FLUSH_POLL: begin
               if (st[BIT_BSY]) rd8(PORT_STATUS);
               else done(STS_OK);
            end
            default: ;
         endcase
      endfunction

      // note one accepted input transfer, returns how many results it causes
      function int take_item(logic [2:0] op, logic [27:0] lba_in, logic [8:0] cnt,
                             logic [15:0] rdata, logic [15:0] wword);
         rsp_type r;
         made.delete();
         if (op <= OP_WRITE) begin
            if (cur == S_IDLE) begin
               cmd  = op[1:0];
               sect = '0;
               word = '0;
               dly  = '0;
               if (op == OP_IDENTIFY) begin
                  lba   = '0;
                  total = '0;
                  cur   = S_SELECT;
                  wr8(PORT_DRIVE, SEL_IDENTIFY);
               end else begin
                  lba   = lba_in;
                  total = (cnt > MAX_SECTORS) ? MAX_SECTORS : cnt;
                  cur   = S_WAIT_READY;
                  rd8(PORT_STATUS);
               end
            end
         end else if (op == OP_RESPONSE) begin
            if (cur != S_IDLE && cur != S_NEED_WORD) respond(rdata);
         end else if (op == OP_SUPPLY) begin
            if (cur == S_NEED_WORD) begin
               cur = S_WRITE_WORD;
               put(KIND_ACCESS, PORT_DATA, 1'b1, 1'b1, wword, '0);
            end
         end
         if (made.size() > 0) begin
            r      = made.pop_back();
            r.last = 1'b1;
            made.push_back(r);
         end
         foreach (made[i]) expected.push_back(made[i]);
         return made.size();
      endfunction

      function void cmp(string name, logic [15:0] e, logic [15:0] a);
         if (e !== a) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
         end
      endfunction

      // compare one accepted result with the oldest expectation
      function void take_rsp(rsp_type got);
         rsp_type want;
         if (expected.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d port %0h data %0h",
                     $time, got.kind, got.bus_port, got.data);
            return;
         end
         want = expected.pop_front();
         cmp("kind", 16'(want.kind), 16'(got.kind));
         cmp("bus_port", 16'(want.bus_port), 16'(got.bus_port));
         cmp("bus_write", 16'(want.bus_write), 16'(got.bus_write));
         cmp("bus_word", 16'(want.bus_word), 16'(got.bus_word));
         cmp("data", want.data, got.data);
         cmp("status_code", 16'(want.status_code), 16'(got.status_code));
         cmp("last", 16'(want.last), 16'(got.last));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   pio_tracker   board = new();
   drive_fault_e fault = PLAN_CLEAN;
   int           err_sector = 0;
   int           useful = 0;         // transfers that caused at least one result
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           hold_ticket = 0;    // bumped by the main flow to ask for a long hold-off
   int           hold_seen = 0;
   int           hold_left = 0;
   int           cmd_rot = 0;
   rsp_type      seen;

   always #4 clock = ~clock;

   ata_pio_host_sequencer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // result side: check each transfer, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.kind        = rsp_tuser;
         seen.bus_port    = rsp_tdata[9:0];
         seen.bus_write   = rsp_tdata[10];
         seen.bus_word    = rsp_tdata[11];
         seen.data        = rsp_tdata[27:12];
         seen.status_code = rsp_tdata[30:28];
         seen.last        = rsp_tlast;
         board.take_rsp(seen);
      end
      if (hold_seen != hold_ticket) begin
         hold_seen = hold_ticket;
         hold_left = 250;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // start_lba, sector_count, bus_read_data, write_word from the lowest bit, zero pad on top
   function automatic logic [71:0] pack_req(logic [27:0] lba, logic [8:0] cnt,
                                            logic [15:0] rdata, logic [15:0] wword);
      return {3'b000, wword, rdata, cnt, lba};
   endfunction

   // an operation the sequencer drops in its present position
   function automatic bit ignored_op(logic [2:0] op);
      return op > OP_SUPPLY
         || (op <= OP_WRITE && board.cur != S_IDLE)
         || (op == OP_RESPONSE && (board.cur == S_IDLE || board.cur == S_NEED_WORD))
         || (op == OP_SUPPLY && board.cur != S_NEED_WORD);
   endfunction

   // emulated drive: answer to the access the sequencer has pending
   function automatic logic [15:0] bus_answer();
      logic [15:0] v;
      v = 16'($urandom);
      case (board.cur)
         S_WAIT_READY, S_ID_BUSY, S_FLUSH_POLL: v[BIT_BSY] = ($urandom_range(3) == 0);
         S_ID_PROBE: begin
            if (fault == PLAN_NO_DRIVE) v[7:0] = 8'h00;
            else if (v[7:0] == 8'h00) v[6] = 1'b1;
         end
         S_ID_SIG_MID, S_ID_SIG_HIGH: begin
            // not-ata signature shows up in mid or high byte
            if (fault == PLAN_NOT_ATA &&
                (board.cur == S_ID_SIG_HIGH || $urandom_range(1) == 1)) begin
               if (v[7:0] == 8'h00) v[0] = 1'b1;
            end else begin
               v[7:0] = 8'h00;
            end
         end
         S_ID_DRQ: v[BIT_DRQ] = (fault != PLAN_ID_ERROR) && ($urandom_range(3) != 0);
         S_ID_ERR: v[BIT_ERR] = (fault == PLAN_ID_ERROR) && ($urandom_range(2) == 0);
         S_SECTOR_POLL: begin
            if (fault == PLAN_DEV_ERROR && board.sect == err_sector) begin
               // keep polling busy until the error is reported
               v[BIT_ERR] = ($urandom_range(1) == 1);
               v[BIT_BSY] = 1'b1;
            end else begin
               v[BIT_ERR] = 1'b0;
               v[BIT_BSY] = ($urandom_range(3) == 0);
               v[BIT_DRQ] = ($urandom_range(4) != 0);
            end
         end
         default: ;
      endcase
      return v;
   endfunction

   // offer one transfer and hold it until taken, then maybe go idle
   task automatic send(input logic [2:0] op, input logic [71:0] payload);
      int n;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= payload;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n = board.take_item(op, payload[27:0], payload[36:28], payload[52:37], payload[68:53]);
      if (n > 0) useful++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // one transfer of an ongoing command, or a dropped one now and then
   task automatic step_once(input int noise_pct);
      logic [2:0] op;
      if ($urandom_range(99) < noise_pct) begin
         do op = 3'($urandom_range(7)); while (!ignored_op(op));
         send(op, pack_req(28'($urandom), 9'($urandom), 16'($urandom), 16'($urandom)));
      end else if (board.cur == S_NEED_WORD) begin
         send(OP_SUPPLY, pack_req(28'($urandom), 9'($urandom), 16'($urandom), 16'($urandom)));
      end else begin
         send(OP_RESPONSE, pack_req(28'($urandom), 9'($urandom), bus_answer(), 16'($urandom)));
      end
   endtask

   // a whole command from start to its done result
   task automatic run_cmd(input logic [2:0] op, input logic [27:0] lba, input logic [8:0] cnt,
                          input drive_fault_e plan, input int at_sector, input int noise_pct);
      fault      = plan;
      err_sector = at_sector;
      send(op, pack_req(lba, cnt, 16'($urandom), 16'($urandom)));
      while (board.cur != S_IDLE) step_once(noise_pct);
   endtask

   task automatic random_cmd();
      logic [2:0]   op;
      logic [8:0]   cnt;
      drive_fault_e plan;
      int           r;
      int           at;
      cmd_rot = (cmd_rot + 1) % 3;
      op  = 3'(cmd_rot);
      r   = $urandom_range(99);
      // mostly short transfers, a few large ones that abort early
      cnt = r < 25 ? 9'd0 : r < 65 ? 9'd1 : r < 85 ? 9'($urandom_range(2, 3))
                                                 : 9'($urandom_range(4, 511));
      at   = 0;
      plan = PLAN_CLEAN;
      if (op == OP_IDENTIFY) begin
         r = $urandom_range(9);
         plan = r < 4 ? PLAN_CLEAN : r < 6 ? PLAN_NO_DRIVE : r < 8 ? PLAN_NOT_ATA
                                                          : PLAN_ID_ERROR;
      end else if (cnt >= 9'd4) begin
         plan = PLAN_DEV_ERROR;
         at   = $urandom_range(1);
      end else if ($urandom_range(3) == 0) begin
         plan = PLAN_DEV_ERROR;
         at   = (cnt == 9'd0) ? 0 : $urandom_range(cnt - 1);
      end
      fault      = plan;
      err_sector = at;
      send(op, pack_req(28'($urandom), cnt, 16'($urandom), 16'($urandom)));
   endtask

   task automatic random_phase(input int target);
      int base;
      base = useful;
      while (useful - base < target || board.cur != S_IDLE) begin
         if (board.cur == S_IDLE) begin
            if ($urandom_range(9) != 0) random_cmd();
            else step_once(100);
         end else begin
            step_once(8);
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // dropped transfers while idle, unused operation codes
      send(OP_RESPONSE, pack_req(28'h0, 9'h0, 16'hFFFF, 16'h0));
      send(OP_SUPPLY, pack_req(28'h0, 9'h0, 16'h0, 16'hFFFF));
      send(3'd5, pack_req(28'hFFFFFFF, 9'h1FF, 16'hFFFF, 16'hFFFF));
      send(3'd6, pack_req(28'h0, 9'h0, 16'h0, 16'h0));
      send(3'd7, pack_req(28'h0, 9'h0, 16'h0, 16'h0));

      // identify failures, the last one with commands and words thrown in while busy
      run_cmd(OP_IDENTIFY, 28'h0, 9'd0, PLAN_NO_DRIVE, 0, 0);
      run_cmd(OP_IDENTIFY, 28'hFFFFFFF, 9'h1FF, PLAN_NOT_ATA, 0, 0);
      run_cmd(OP_IDENTIFY, 28'h0, 9'd0, PLAN_ID_ERROR, 0, 30);

      // zero-count read and write, extreme addresses
      run_cmd(OP_READ, 28'hFFFFFFF, 9'd0, PLAN_CLEAN, 0, 0);
      run_cmd(OP_WRITE, 28'h0000000, 9'd0, PLAN_CLEAN, 0, 0);

      // saturated and maximum counts, cut short by a device error
      run_cmd(OP_READ, 28'h5A5A5A5, 9'd511, PLAN_DEV_ERROR, 0, 0);
      run_cmd(OP_WRITE, 28'hA5A5A5A, 9'd256, PLAN_DEV_ERROR, 0, 0);

      // no idling, with one long result hold-off so the input side backs up
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_ticket++;
      random_phase(150);

      send_idle_pct = 58;
      random_phase(150);

      send_idle_pct  = 0;
      recv_stall_pct = 58;
      random_phase(150);

      send_idle_pct  = 9;
      recv_stall_pct = 9;
      random_phase(150);

      req_tvalid <= 1'b0;
      while (board.expected.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (board.errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
